### hdl/tkst_pkg.sv
// ----------------------------------------------------------------------------
// Top-k score table package
// Shared widths, table entry type, sequencer states and compare unit control.
// ----------------------------------------------------------------------------
`default_nettype none

package tkst_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   localparam int ID_W        = 8;
   localparam int SCORE_W     = 16;
   localparam int RANK_W      = 4;

   // stream payload widths, padded to whole bytes
   localparam int REQ_DATA_W  = 24;
   localparam int RSP_FIELD_W = RANK_W + ID_W + SCORE_W;
   localparam int RSP_DATA_W  = 32;
   localparam int RSP_PAD_W   = RSP_DATA_W - RSP_FIELD_W;

   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [CNT_W-1:0] cnt_type;

   typedef struct packed {
      logic [ID_W-1:0]    id;
      logic [SCORE_W-1:0] score;
   } entry_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MIN_SCAN,
      ST_MIN_WR,
      ST_SORT_START,
      ST_SORT_SCAN,
      ST_SWAP_A,
      ST_SWAP_B,
      ST_OUT_RD,
      ST_OUT_LD
   } state_type;

   typedef struct packed {
      logic init;      // first entry of a scan: load best and anchor
      logic en;        // entry on the read port takes part in the compare
      logic find_max;  // 1: track maximum, 0: track minimum
   } best_ctl_type;

endpackage

`default_nettype wire

### hdl/top_k_score_table_top.sv
// ----------------------------------------------------------------------------
// Top-k score table
// Keeps up to TABLE_DEPTH (player, score) entries sorted by descending score
// and reads the whole table out after every offered entry.
//
// Usage:
//   req_*  : one transfer offers a player id and a score. While the table is
//            not full the entry is appended; once full it replaces the first
//            minimum, but only if its score is strictly greater.
//   rsp_*  : after each offer the table streams out in rank order, one
//            transfer per entry, rank 0 first, rsp_tlast on the final entry.
//   Timing : req_tready is high only while idle. For N entries in the table
//            an offer is accepted, a minimum scan and replace runs when full,
//            then N-1 selection passes run, each scanning from the pass head
//            and followed by a swap when the maximum lies elsewhere; the sort
//            then closes and each result is read and loaded for output.
//            Every step is paced by the single memory read port feeding the
//            one shared comparator.
//   Reset  : synchronous, active high; empties the table and drops any
//            pending result.
//   Stall  : while rsp_tready is low the current result holds in the output
//            register and readout waits; nothing is lost.
// ----------------------------------------------------------------------------
`default_nettype none

module top_k_score_table_top (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // request: [7:0] player_id, [23:8] new_score
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [tkst_pkg::REQ_DATA_W-1:0] req_tdata,
   // response: [3:0] rank, [11:4] entry_player, [27:12] entry_score, rest 0
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic [tkst_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                 rsp_tlast
);

   tkst_pkg::state_type    state_ff, state_in;
   tkst_pkg::cnt_type      cnt_ff, cnt_in;      // valid entries in the table
   tkst_pkg::cnt_type      ptr_ff, ptr_in;      // read pointer of scans/readout
   tkst_pkg::cnt_type      pass_ff, pass_in;    // selection sort position
   tkst_pkg::entry_type    in_entry_ff, in_entry_in;
   logic                   rd_vld_ff, rd_vld_in;
   tkst_pkg::idx_type      rd_idx_ff, rd_idx_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [tkst_pkg::RANK_W-1:0]    rsp_rank_ff, rsp_rank_in;
   tkst_pkg::entry_type            rsp_entry_ff, rsp_entry_in;
   logic                           rsp_last_ff, rsp_last_in;

   logic                   req_xfer;
   tkst_pkg::entry_type    req_entry;
   logic                   scan_state;
   logic                   scan_issue;
   logic                   scan_done;
   logic                   table_full;
   logic                   rsp_load;
   logic                   ptr_at_end;
   tkst_pkg::cnt_type      scan_base;

   logic                   wr_en;
   tkst_pkg::idx_type      wr_addr;
   tkst_pkg::entry_type    wr_data;
   logic                   rd_en;
   tkst_pkg::idx_type      rd_addr;
   tkst_pkg::entry_type    rd_data;

   tkst_pkg::best_ctl_type best_ctl;
   tkst_pkg::entry_type    best_entry;
   tkst_pkg::idx_type      best_idx;
   tkst_pkg::entry_type    anchor_entry;

   // ---------------------------------------------------------------- status
   assign req_tready  = (state_ff == tkst_pkg::ST_IDLE);
   assign req_xfer    = req_tvalid && req_tready;
   assign req_entry.id    = req_tdata[tkst_pkg::ID_W-1:0];
   assign req_entry.score = req_tdata[tkst_pkg::ID_W +: tkst_pkg::SCORE_W];

   assign table_full  = (cnt_ff == tkst_pkg::CNT_W'(tkst_pkg::TABLE_DEPTH));
   assign scan_state  = (state_ff == tkst_pkg::ST_MIN_SCAN) ||
                        (state_ff == tkst_pkg::ST_SORT_SCAN);
   assign scan_issue  = scan_state && (ptr_ff < cnt_ff);
   // last read has landed in the compare unit once the pipe is empty
   assign scan_done   = scan_state && (ptr_ff >= cnt_ff) && !rd_vld_ff;
   assign scan_base   = (state_ff == tkst_pkg::ST_SORT_SCAN) ? pass_ff : '0;
   assign ptr_at_end  = ((ptr_ff + tkst_pkg::CNT_W'(1)) == cnt_ff);
   assign rsp_load    = (state_ff == tkst_pkg::ST_OUT_LD) &&
                        (!rsp_valid_ff || rsp_tready);

   // compare unit: minimum search when full, maximum search per sort pass
   assign best_ctl.init     = scan_state && rd_vld_ff &&
                              (rd_idx_ff == scan_base[tkst_pkg::IDX_W-1:0]);
   assign best_ctl.en       = scan_state && rd_vld_ff;
   assign best_ctl.find_max = (state_ff == tkst_pkg::ST_SORT_SCAN);

   // ------------------------------------------------------------ next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tkst_pkg::ST_IDLE: begin
            if (req_xfer) begin
               state_in = table_full ? tkst_pkg::ST_MIN_SCAN : tkst_pkg::ST_SORT_START;
            end
         end
         tkst_pkg::ST_MIN_SCAN: begin
            if (scan_done) begin
               state_in = tkst_pkg::ST_MIN_WR;
            end
         end
         tkst_pkg::ST_MIN_WR: begin
            state_in = tkst_pkg::ST_SORT_START;
         end
         tkst_pkg::ST_SORT_START: begin
            if ((pass_ff + tkst_pkg::CNT_W'(1)) >= cnt_ff) begin
               state_in = tkst_pkg::ST_OUT_RD;
            end else begin
               state_in = tkst_pkg::ST_SORT_SCAN;
            end
         end
         tkst_pkg::ST_SORT_SCAN: begin
            if (scan_done) begin
               if (best_idx != pass_ff[tkst_pkg::IDX_W-1:0]) begin
                  state_in = tkst_pkg::ST_SWAP_A;
               end else begin
                  state_in = tkst_pkg::ST_SORT_START;
               end
            end
         end
         tkst_pkg::ST_SWAP_A: begin
            state_in = tkst_pkg::ST_SWAP_B;
         end
         tkst_pkg::ST_SWAP_B: begin
            state_in = tkst_pkg::ST_SORT_START;
         end
         tkst_pkg::ST_OUT_RD: begin
            state_in = tkst_pkg::ST_OUT_LD;
         end
         tkst_pkg::ST_OUT_LD: begin
            if (rsp_load) begin
               state_in = ptr_at_end ? tkst_pkg::ST_IDLE : tkst_pkg::ST_OUT_RD;
            end
         end
         default: begin
            state_in = tkst_pkg::ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------- outputs
   always_comb begin
      cnt_in      = cnt_ff;
      ptr_in      = ptr_ff;
      pass_in     = pass_ff;
      in_entry_in = in_entry_ff;
      wr_en       = 1'b0;
      wr_addr     = best_idx;
      wr_data     = in_entry_ff;
      rd_en       = 1'b0;
      rd_addr     = ptr_ff[tkst_pkg::IDX_W-1:0];

      unique case (state_ff)
         tkst_pkg::ST_IDLE: begin
            if (req_xfer) begin
               in_entry_in = req_entry;
               ptr_in      = '0;
               pass_in     = '0;
               if (!table_full) begin
                  // append at the end of the table
                  wr_en   = 1'b1;
                  wr_addr = cnt_ff[tkst_pkg::IDX_W-1:0];
                  wr_data = req_entry;
                  cnt_in  = cnt_ff + tkst_pkg::CNT_W'(1);
               end
            end
         end
         tkst_pkg::ST_MIN_SCAN: begin
            if (scan_issue) begin
               rd_en  = 1'b1;
               ptr_in = ptr_ff + tkst_pkg::CNT_W'(1);
            end
         end
         tkst_pkg::ST_MIN_WR: begin
            // replace the first minimum only on a strictly greater score
            wr_en   = (in_entry_ff.score > best_entry.score);
            wr_addr = best_idx;
            wr_data = in_entry_ff;
            pass_in = '0;
         end
         tkst_pkg::ST_SORT_START: begin
            ptr_in = pass_ff;
            if ((pass_ff + tkst_pkg::CNT_W'(1)) >= cnt_ff) begin
               ptr_in = '0;
            end
         end
         tkst_pkg::ST_SORT_SCAN: begin
            if (scan_issue) begin
               rd_en  = 1'b1;
               ptr_in = ptr_ff + tkst_pkg::CNT_W'(1);
            end
            if (scan_done && (best_idx == pass_ff[tkst_pkg::IDX_W-1:0])) begin
               pass_in = pass_ff + tkst_pkg::CNT_W'(1);
            end
         end
         tkst_pkg::ST_SWAP_A: begin
            // move the pass head to where the maximum was
            wr_en   = 1'b1;
            wr_addr = best_idx;
            wr_data = anchor_entry;
         end
         tkst_pkg::ST_SWAP_B: begin
            wr_en   = 1'b1;
            wr_addr = pass_ff[tkst_pkg::IDX_W-1:0];
            wr_data = best_entry;
            pass_in = pass_ff + tkst_pkg::CNT_W'(1);
         end
         tkst_pkg::ST_OUT_RD: begin
            rd_en = 1'b1;
         end
         tkst_pkg::ST_OUT_LD: begin
            if (rsp_load) begin
               ptr_in = ptr_ff + tkst_pkg::CNT_W'(1);
            end
         end
         default: begin
            cnt_in = cnt_ff;
         end
      endcase
   end

   // read pipe tracking: which address sits in the read register
   assign rd_vld_in = rd_en;
   assign rd_idx_in = rd_en ? rd_addr : rd_idx_ff;

   // ------------------------------------------------------ output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_rank_in  = rsp_rank_ff;
      rsp_entry_in = rsp_entry_ff;
      rsp_last_in  = rsp_last_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_rank_in  = tkst_pkg::RANK_W'(ptr_ff);
         rsp_entry_in = rd_data;
         rsp_last_in  = ptr_at_end;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tkst_pkg::ST_IDLE;
         cnt_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ptr_ff       <= ptr_in;
      pass_ff      <= pass_in;
      in_entry_ff  <= in_entry_in;
      rd_idx_ff    <= rd_idx_in;
      rsp_rank_ff  <= rsp_rank_in;
      rsp_entry_ff <= rsp_entry_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {{tkst_pkg::RSP_PAD_W{1'b0}}, rsp_entry_ff.score,
                        rsp_entry_ff.id, rsp_rank_ff};

   // ------------------------------------------------------------ instances
   tkst_mem u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   tkst_best u_best (
      .clock        (clock),
      .ctl          (best_ctl),
      .rd_entry     (rd_data),
      .rd_idx       (rd_idx_ff),
      .best_entry   (best_entry),
      .best_idx     (best_idx),
      .anchor_entry (anchor_entry)
   );

endmodule

`default_nettype wire

### hdl/tkst_mem.sv
// ----------------------------------------------------------------------------
// Top-k score table storage
// One write port and one read port with a registered read; read data holds
// until the next read strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module tkst_mem (
   input  wire logic                clock,
   input  wire logic                wr_en,
   input  wire tkst_pkg::idx_type   wr_addr,
   input  wire tkst_pkg::entry_type wr_data,
   input  wire logic                rd_en,
   input  wire tkst_pkg::idx_type   rd_addr,
   output tkst_pkg::entry_type      rd_data
);

   tkst_pkg::entry_type mem_ff [tkst_pkg::TABLE_DEPTH];
   tkst_pkg::entry_type rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_ff;

endmodule

`default_nettype wire

### hdl/tkst_best.sv
// ----------------------------------------------------------------------------
// Top-k score table compare unit
// Shared score comparator that tracks the first minimum or first maximum of a
// scan, and keeps the scan's first entry as the swap partner.
// ----------------------------------------------------------------------------
`default_nettype none

module tkst_best (
   input  wire logic                   clock,
   input  wire tkst_pkg::best_ctl_type ctl,
   input  wire tkst_pkg::entry_type    rd_entry,
   input  wire tkst_pkg::idx_type      rd_idx,
   output tkst_pkg::entry_type         best_entry,
   output tkst_pkg::idx_type           best_idx,
   output tkst_pkg::entry_type         anchor_entry
);

   tkst_pkg::entry_type best_entry_ff, best_entry_in;
   tkst_pkg::idx_type   best_idx_ff, best_idx_in;
   tkst_pkg::entry_type anchor_ff, anchor_in;
   logic                better;

   // strict compare keeps the lowest index among ties
   assign better = ctl.find_max ? (rd_entry.score > best_entry_ff.score)
                                : (rd_entry.score < best_entry_ff.score);

   always_comb begin
      best_entry_in = best_entry_ff;
      best_idx_in   = best_idx_ff;
      anchor_in     = anchor_ff;
      if (ctl.init) begin
         best_entry_in = rd_entry;
         best_idx_in   = rd_idx;
         anchor_in     = rd_entry;
      end else if (ctl.en && better) begin
         best_entry_in = rd_entry;
         best_idx_in   = rd_idx;
      end
   end

   always_ff @(posedge clock) begin
      best_entry_ff <= best_entry_in;
      best_idx_ff   <= best_idx_in;
      anchor_ff     <= anchor_in;
   end

   assign best_entry   = best_entry_ff;
   assign best_idx     = best_idx_ff;
   assign anchor_entry = anchor_ff;

endmodule

`default_nettype wire
